>>> hdl/mpps_pkg.sv
// ----------------------------------------------------------------------------
// mpps_pkg
// Shared constants, request and register codes, and types of the multi-pin
// pulse stretcher.
// ----------------------------------------------------------------------------
package mpps_pkg;

    localparam int PIN_COUNT = 8;
    localparam int TIME_BITS = 48;

    // Width that holds a deadline sum before saturation.
    localparam int SUM_BITS = ((TIME_BITS > 24) ? TIME_BITS : 24) + 1;

    localparam int MAP_BITS   = 32;
    localparam int PULSE_BITS = 24;
    localparam int ADDR_BITS  = 16;
    localparam int CFG_BITS   = 32;
    localparam int CFG_INDEX_BITS = 2;

    localparam int REQ_BITS    = 2;
    localparam int CHAN_BITS   = 3;
    localparam int SAMPLE_BITS = 48;
    localparam int BYTE_BITS   = 8;

    localparam logic [REQ_BITS-1:0] REQ_EVENT = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_CHECK = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_STOP  = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PIN_MAP       = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PULSE_SAMPLES = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PORT_ADDRESS  = 2'd2;

    localparam logic [PULSE_BITS-1:0] PULSE_RESET = 24'd300;

    typedef logic [TIME_BITS-1:0] time_t;

    // Token that walks the row of cells, one cell per cycle.
    typedef struct packed {
        logic valid;
        logic changed;
    } token_t;

    // Command of the item in flight, held steady while the token walks.
    typedef struct packed {
        logic [REQ_BITS-1:0]  req;
        logic [PIN_COUNT-1:0] hit;
        time_t                now;
        time_t                deadline;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

endpackage

>>> hdl/mpps_intf.sv
// ----------------------------------------------------------------------------
// mpps_intf
// Handshake channels of the pulse stretcher: input items, results and
// configuration writes.
// ----------------------------------------------------------------------------
interface mpps_item_if;
    logic                                valid;
    logic                                ready;
    logic [mpps_pkg::REQ_BITS-1:0]       req_type;
    logic [mpps_pkg::CHAN_BITS-1:0]      channel;
    logic                                level;
    logic [mpps_pkg::SAMPLE_BITS-1:0]    sample_time;

    modport source (output valid, req_type, channel, level, sample_time, input ready);
    modport sink (input valid, req_type, channel, level, sample_time, output ready);
endinterface

interface mpps_result_if;
    logic                              valid;
    logic                              ready;
    logic [mpps_pkg::BYTE_BITS-1:0]    pin_byte;
    logic                              port_write;
    logic [mpps_pkg::ADDR_BITS-1:0]    write_address;

    modport source (output valid, pin_byte, port_write, write_address, input ready);
    modport sink (input valid, pin_byte, port_write, write_address, output ready);
endinterface

interface mpps_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [mpps_pkg::CFG_INDEX_BITS-1:0]   index;
    logic [mpps_pkg::CFG_BITS-1:0]         data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/multi_pin_pulse_stretcher.sv
// ----------------------------------------------------------------------------
// multi_pin_pulse_stretcher
// Retriggerable one-shot per output pin, run by TTL events, checks and stops.
// ----------------------------------------------------------------------------
// An accepted word sets the start register, then its token walks the
// PIN_COUNT cells; a new word is taken once its result is registered.
// The result register frees the input side while a result waits downstream.
// Reset: all pins low and unarmed, pin_map 0, pulse_samples 300,
// port_address 0. Deadlines are undefined until an event writes them.
module multi_pin_pulse_stretcher (
    input  logic          clk,
    input  logic          rst_n,
    mpps_item_if.sink     item,
    mpps_result_if.source result,
    mpps_cfg_if.sink      cfg
);
    import mpps_pkg::*;

    logic [MAP_BITS-1:0]   pin_map_reg;
    logic [PULSE_BITS-1:0] pulse_samples_reg;
    logic [ADDR_BITS-1:0]  port_address_reg;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic   start_reg, start_next;
    logic   changed_reg, changed_next;

    logic                 out_valid_reg, out_valid_next;
    logic [BYTE_BITS-1:0] out_byte_reg, out_byte_next;
    logic                 out_write_reg, out_write_next;
    logic [ADDR_BITS-1:0] out_addr_reg, out_addr_next;

    token_t               chain_in, chain_out;
    logic [PIN_COUNT-1:0] levels, armed;

    logic                 accept;
    logic                 out_free;
    logic [3:0]           nibble;
    time_t                now;
    logic [SUM_BITS-1:0]  sum;
    logic [PIN_COUNT-1:0] hit;

    // Configuration writes.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_map_reg       <= '0;
            pulse_samples_reg <= PULSE_RESET;
            port_address_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_PIN_MAP:       pin_map_reg       <= cfg.data;
                CFG_PULSE_SAMPLES: pulse_samples_reg <= cfg.data[PULSE_BITS-1:0];
                CFG_PORT_ADDRESS:  port_address_reg  <= cfg.data[ADDR_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Decode the incoming word: target pin and saturated deadline.
    assign accept = item.valid && item.ready;
    assign nibble = pin_map_reg[{item.channel, 2'b00} +: 4];
    assign now    = TIME_BITS'(item.sample_time);
    assign sum    = SUM_BITS'(now) + SUM_BITS'(pulse_samples_reg);

    for (genvar k = 0; k < PIN_COUNT; k++)
    begin : g_hit
        assign hit[k] = (item.req_type == REQ_EVENT) && item.level
                        && (nibble == 4'(k + 1));
    end

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        start_next     = 1'b0;
        changed_next   = changed_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_byte_next  = out_byte_reg;
        out_write_next = out_write_reg;
        out_addr_next  = out_addr_reg;
        item.ready     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                item.ready = 1'b1;
                if (item.valid)
                begin
                    cmd_next.req = item.req_type;
                    cmd_next.hit = hit;
                    cmd_next.now = now;
                    if (sum[SUM_BITS-1:TIME_BITS] != '0)
                    begin
                        cmd_next.deadline = '1;
                    end
                    else
                    begin
                        cmd_next.deadline = sum[TIME_BITS-1:0];
                    end
                    start_next = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (chain_out.valid)
                begin
                    changed_next = chain_out.changed;
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = BYTE_BITS'(levels);
                        out_write_next = chain_out.changed;
                        out_addr_next  = chain_out.changed ? port_address_reg : '0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = BYTE_BITS'(levels);
                    out_write_next = changed_reg;
                    out_addr_next  = changed_reg ? port_address_reg : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        changed_reg   <= changed_next;
        out_byte_reg  <= out_byte_next;
        out_write_reg <= out_write_next;
        out_addr_reg  <= out_addr_next;
    end

    assign chain_in.valid   = start_reg;
    assign chain_in.changed = 1'b0;

    mpps_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_reg),
        .token_in  (chain_in),
        .token_out (chain_out),
        .levels    (levels),
        .armed     (armed)
    );

    assign result.valid         = out_valid_reg;
    assign result.pin_byte      = out_byte_reg;
    assign result.port_write    = out_write_reg;
    assign result.write_address = out_addr_reg;

`ifndef SYNTHESIS
    // A pin is never armed while its level is low.
    a_armed_high: assert property (@(posedge clk) disable iff (!rst_n)
        (armed & ~levels) == '0)
        else $error("armed pin with low level");

    // Only one word is in flight: no new word is taken the cycle after one.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !item.ready)
        else $error("word accepted while another is in flight");

    // The token leaves the row only while the control waits for it.
    a_token_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.valid |-> (state_reg == ST_RUN))
        else $error("token left the row outside of a run");

    // A stop word leaves every pin low in its result.
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_out.valid && (cmd_reg.req == REQ_STOP)) |-> (levels == '0))
        else $error("pins still high after stop");
`endif

endmodule

>>> hdl/mpps_cell.sv
// ----------------------------------------------------------------------------
// mpps_cell
// One output pin: its level, armed flag and turn-off deadline. Acts on the
// command when the token reaches it and hands the token on.
// ----------------------------------------------------------------------------
module mpps_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  mpps_pkg::cmd_t   cmd,
    input  logic             hit,
    input  mpps_pkg::token_t token_in,
    output mpps_pkg::token_t token_out,
    output logic             level,
    output logic             armed
);
    import mpps_pkg::*;

    logic   level_reg, level_next;
    logic   armed_reg, armed_next;
    time_t  deadline_reg, deadline_next;
    logic   load_deadline;
    logic   mine;
    token_t token_reg, token_next;

    always_comb
    begin
        level_next    = level_reg;
        armed_next    = armed_reg;
        deadline_next = cmd.deadline;
        load_deadline = 1'b0;
        mine          = 1'b0;
        if (token_in.valid)
        begin
            case (cmd.req)
                REQ_EVENT:
                begin
                    if (hit)
                    begin
                        level_next    = 1'b1;
                        armed_next    = 1'b1;
                        load_deadline = 1'b1;
                        mine          = 1'b1;
                    end
                end
                REQ_CHECK:
                begin
                    if (armed_reg && (cmd.now >= deadline_reg))
                    begin
                        level_next = 1'b0;
                        armed_next = 1'b0;
                        mine       = 1'b1;
                    end
                end
                REQ_STOP:
                begin
                    level_next = 1'b0;
                    armed_next = 1'b0;
                    mine       = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        token_next.valid   = token_in.valid;
        token_next.changed = token_in.changed | mine;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b0;
            armed_reg <= 1'b0;
            token_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
            armed_reg <= armed_next;
            token_reg <= token_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_deadline)
        begin
            deadline_reg <= deadline_next;
        end
    end

    assign token_out = token_reg;
    assign level     = level_reg;
    assign armed     = armed_reg;

endmodule

>>> hdl/mpps_chain.sv
// ----------------------------------------------------------------------------
// mpps_chain
// Row of pin cells; the token enters at pin 1 and leaves after the last pin.
// ----------------------------------------------------------------------------
module mpps_chain (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mpps_pkg::cmd_t                 cmd,
    input  mpps_pkg::token_t               token_in,
    output mpps_pkg::token_t               token_out,
    output logic [mpps_pkg::PIN_COUNT-1:0] levels,
    output logic [mpps_pkg::PIN_COUNT-1:0] armed
);
    import mpps_pkg::*;

    token_t tokens [PIN_COUNT+1];

    assign tokens[0] = token_in;

    for (genvar k = 0; k < PIN_COUNT; k++)
    begin : g_cell
        mpps_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .hit       (cmd.hit[k]),
            .token_in  (tokens[k]),
            .token_out (tokens[k+1]),
            .level     (levels[k]),
            .armed     (armed[k])
        );
    end

    assign token_out = tokens[PIN_COUNT];

endmodule
